[sv/hmac_pkg.sv]
package hmac_pkg;

    localparam int DIG_W = 256;

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        BLK_MSG   = 2'd0,
        BLK_IPAD  = 2'd1,
        BLK_OPAD  = 2'd2,
        BLK_OUTER = 2'd3
    } blk_kind_t;

    typedef enum logic [2:0] {
        CFG_KEY0 = 3'd0,
        CFG_KEY1 = 3'd1,
        CFG_KEY2 = 3'd2,
        CFG_KEY3 = 3'd3,
        CFG_KLEN = 3'd4
    } cfg_idx_t;

    localparam logic [DIG_W-1:0] SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

[sv/hmac_round.sv]
module hmac_round
    import hmac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIG_W-1:0]     chain_in,
    input  logic [511:0]         block,
    output logic                 done,
    output logic [DIG_W-1:0]     chain_out
);

    word_t              w_reg [16];
    word_t              w_next;
    logic [DIG_W-1:0]   st_reg;
    logic [DIG_W-1:0]   st_next;
    logic [DIG_W-1:0]   cv_reg;
    logic [5:0]         rnd_reg;
    logic               busy_reg;
    logic               done_reg;
    word_t              a, b, c, d, e, f, g, h, t1, t2, s0, s1;

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        {a, b, c, d, e, f, g, h} = st_reg;
        s0 = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_next = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + round_k(rnd_reg) + w_reg[0];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        st_next = {t1 + t2, a, b, c, d + t1, e, f, g};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            st_reg <= chain_in;
            cv_reg <= chain_in;
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[511-32*i -: 32];
            end
        end
        else if (busy_reg)
        begin
            st_reg <= st_next;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chain_out[DIG_W-1-32*i -: 32] = cv_reg[DIG_W-1-32*i -: 32]
                                          + st_reg[DIG_W-1-32*i -: 32];
        end
    end

    assign done = done_reg;

endmodule

[sv/hmac_sha256_engine.sv]
// HMAC-SHA256 over a byte stream of 64-bit words, first byte in the top bits.
// Keys of up to KEY_BYTES bytes come from the register port (write only while
// idle). One shared SHA-256 round unit does one round per cycle. A word is taken
// while idle, then its bytes go into the block buffer one at a time, and no new word
// is taken until that is done; a word that fills a block also stalls for its
// compression. The first word of a message adds one ipad block; the last word adds
// one or two padding blocks, the opad block and the outer block, then the four MAC
// words are offered on m_axis one at a time.
module hmac_sha256_engine
    import hmac_pkg::*;
#(
    parameter int KEY_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // msg_word[63:0], msg_bytes[67:64], zero
    input  logic        s_axis_tlast,   // msg_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // mac_word[63:0], mac_index[65:64], zero
    output logic        m_axis_tlast    // mac_final
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_BYTE  = 7'b0000010,
        ST_PAD   = 7'b0000100,
        ST_START = 7'b0001000,
        ST_WAIT  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_NEXT  = 7'b1000000
    } state_t;

    state_t             state_reg;
    logic [63:0]        key_reg [4];
    logic [5:0]         klen_reg;
    logic [DIG_W-1:0]   chain_reg;
    logic [DIG_W-1:0]   inner_reg;
    logic [511:0]       buf_reg;
    logic [63:0]        total_reg;
    logic               phase_reg;
    logic [63:0]        word_reg;
    logic [3:0]         cnt_reg;
    logic               last_reg;
    blk_kind_t          kind_reg;
    logic               padded_reg;
    logic               lenpend_reg;
    logic [1:0]         oidx_reg;
    logic               core_start;
    logic               core_done;
    logic [DIG_W-1:0]   core_out;
    logic [DIG_W-1:0]   core_cin;
    logic [511:0]       core_blk;
    logic [511:0]       key_blk;
    logic [511:0]       pad_blk;
    logic [5:0]         klen_eff;
    logic [5:0]         pos;

    always_comb
    begin
        klen_eff = (klen_reg > 6'(KEY_BYTES)) ? 6'(KEY_BYTES) : klen_reg;
        key_blk = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (6'(i) < klen_eff)
            begin
                key_blk[511-8*i -: 8] = key_reg[i/8][63-8*(i%8) -: 8];
            end
        end
    end

    always_comb
    begin
        core_cin = chain_reg;
        core_blk = buf_reg;
        case (kind_reg)
            BLK_IPAD:  begin core_cin = SHA_IV; core_blk = key_blk ^ {64{8'h36}}; end
            BLK_OPAD:  begin core_cin = SHA_IV; core_blk = key_blk ^ {64{8'h5c}}; end
            BLK_OUTER: core_blk = {inner_reg, 8'h80, 232'd0, 16'h0300};
            default:   ;
        endcase
    end

    // append 0x80, zero fill, then 64-bit bit length if it fits
    always_comb
    begin
        pad_blk = buf_reg;
        pad_blk[511-8*pos -: 8] = 8'h80;
        for (int i = 0; i < 64; i++)
        begin
            if (6'(i) > pos)
            begin
                pad_blk[511-8*i -: 8] = 8'h00;
            end
        end
        if (pos < 6'd56)
        begin
            pad_blk[63:0] = {total_reg[60:0], 3'b000};
        end
    end

    assign core_start = (state_reg == ST_START);
    assign pos = total_reg[5:0];

    hmac_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .chain_in  (core_cin),
        .block     (core_blk),
        .done      (core_done),
        .chain_out (core_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            key_reg     <= '{default: '0};
            klen_reg    <= 6'd32;
            chain_reg   <= SHA_IV;
            inner_reg   <= '0;
            buf_reg     <= '0;
            word_reg    <= '0;
            total_reg   <= '0;
            phase_reg   <= 1'b0;
            kind_reg    <= BLK_MSG;
            padded_reg  <= 1'b0;
            lenpend_reg <= 1'b0;
            oidx_reg    <= '0;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY0: key_reg[0] <= cfg_data;
                    CFG_KEY1: key_reg[1] <= cfg_data;
                    CFG_KEY2: key_reg[2] <= cfg_data;
                    CFG_KEY3: key_reg[3] <= cfg_data;
                    CFG_KLEN: klen_reg   <= cfg_data[5:0];
                    default:  ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        word_reg   <= s_axis_tdata[63:0];
                        cnt_reg    <= (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
                        last_reg   <= s_axis_tlast;
                        padded_reg <= 1'b0;
                        if (!phase_reg)
                        begin
                            kind_reg  <= BLK_IPAD;
                            phase_reg <= 1'b1;
                            total_reg <= 64'd64;
                            state_reg <= ST_START;
                        end
                        else
                        begin
                            state_reg <= ST_BYTE;
                        end
                    end
                end
                ST_BYTE:
                begin
                    if (cnt_reg != 4'd0)
                    begin
                        buf_reg[511-8*pos -: 8] <= word_reg[63:56];
                        word_reg  <= {word_reg[55:0], 8'd0};
                        cnt_reg   <= cnt_reg - 4'd1;
                        total_reg <= total_reg + 64'd1;
                        if (pos == 6'd63)
                        begin
                            kind_reg  <= BLK_MSG;
                            state_reg <= ST_START;
                        end
                    end
                    else if (last_reg)
                    begin
                        state_reg <= ST_PAD;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PAD:
                begin
                    kind_reg <= BLK_MSG;
                    if (!padded_reg)
                    begin
                        buf_reg <= pad_blk;
                        if (pos >= 6'd56)
                        begin
                            lenpend_reg <= 1'b1;
                        end
                        padded_reg <= 1'b1;
                        state_reg  <= ST_START;
                    end
                    else
                    begin
                        buf_reg     <= {448'd0, total_reg[60:0], 3'b000};
                        lenpend_reg <= 1'b0;
                        state_reg   <= ST_START;
                    end
                end
                ST_START:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (core_done)
                    begin
                        chain_reg <= core_out;
                        unique case (kind_reg)
                            BLK_IPAD:
                            begin
                                state_reg <= ST_BYTE;
                            end
                            BLK_MSG:
                            begin
                                if (!padded_reg)
                                begin
                                    state_reg <= ST_BYTE;
                                end
                                else if (lenpend_reg)
                                begin
                                    state_reg <= ST_PAD;
                                end
                                else
                                begin
                                    inner_reg <= core_out;
                                    kind_reg  <= BLK_OPAD;
                                    state_reg <= ST_START;
                                end
                            end
                            BLK_OPAD:
                            begin
                                kind_reg  <= BLK_OUTER;
                                state_reg <= ST_START;
                            end
                            default:
                            begin
                                oidx_reg  <= '0;
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        oidx_reg <= oidx_reg + 2'd1;
                        if (oidx_reg == 2'd3)
                        begin
                            state_reg <= ST_NEXT;
                        end
                    end
                end
                ST_NEXT:
                begin
                    chain_reg <= SHA_IV;
                    total_reg <= '0;
                    phase_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {6'd0, oidx_reg, chain_reg[DIG_W-1-64*oidx_reg -: 64]};
    assign m_axis_tlast  = (oidx_reg == 2'd3);

endmodule

[sv/hmac_sha256_engine_chk.sv]
module hmac_sha256_engine_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while MAC pending");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed under stall");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[65:64] == 2'd3)))
        else $error("tlast does not match index");

    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tdata[65:64] == $past(m_axis_tdata[65:64]) + 2'd1)
        else $error("MAC words out of order");

endmodule

bind hmac_sha256_engine hmac_sha256_engine_chk u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
    import hmac_pkg::*;
;

    typedef struct {
        bit [63:0] word;
        bit [1:0]  index;
        bit        final_word;
    } mac_t;

    class mac_board;
        bit [31:0] rk[64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        bit [31:0] h0[8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        bit [63:0] key_reg[4];
        bit [5:0]  key_len = 6'd32;
        bit [31:0] chain[8] = h0;
        bit [7:0]  blk[64];
        bit [63:0] byte_count;
        bit        in_message;
        mac_t      pending[$];
        int        errors;

        function void set_reg(cfg_idx_t idx, bit [63:0] val);
            if (idx == CFG_KLEN)
                key_len = val[5:0];
            else
                key_reg[idx] = val;
        endfunction

        function bit [31:0] rotr(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            bit [31:0] w[16];
            bit [31:0] a[8];
            bit [31:0] t1, t2, wi, x15, x2;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            a = chain;
            for (int i = 0; i < 64; i++)
            begin
                if (i < 16)
                    wi = w[i];
                else
                begin
                    x15 = w[(i + 1) & 15];
                    x2 = w[(i + 14) & 15];
                    wi = w[i & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                       + w[(i + 9) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                    w[i & 15] = wi;
                end
                t1 = a[7] + (rotr(a[4], 6) ^ rotr(a[4], 11) ^ rotr(a[4], 25))
                   + ((a[4] & a[5]) ^ (~a[4] & a[6])) + rk[i] + wi;
                t2 = (rotr(a[0], 2) ^ rotr(a[0], 13) ^ rotr(a[0], 22))
                   + ((a[0] & a[1]) ^ (a[0] & a[2]) ^ (a[1] & a[2]));
                for (int j = 7; j > 0; j--)
                    a[j] = a[j-1];
                a[4] += t1;
                a[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] += a[i];
        endfunction

        function void key_block(bit [7:0] pad);
            int kl;
            bit [7:0] kb;
            kl = (key_len > 32) ? 32 : key_len;
            chain = h0;
            for (int i = 0; i < 64; i++)
            begin
                kb = (i < kl) ? key_reg[i >> 3][63 - 8 * (i & 7) -: 8] : 8'h00;
                blk[i] = kb ^ pad;
            end
            compress();
        endfunction

        function void absorb(bit [7:0] b);
            blk[byte_count[5:0]] = b;
            byte_count++;
            if (byte_count[5:0] == 0)
                compress();
        endfunction

        function void note_item(bit [63:0] word, bit [3:0] nbytes, bit last);
            int n;
            bit [63:0] bits;
            bit [31:0] inner[8];
            n = (nbytes > 8) ? 8 : nbytes;
            if (!in_message)
            begin
                key_block(8'h36);
                byte_count = 64;
                in_message = 1;
            end
            for (int i = 0; i < n; i++)
                absorb(word[63 - 8 * i -: 8]);
            if (!last)
                return;
            bits = byte_count << 3;
            absorb(8'h80);
            while (byte_count[5:0] != 56)
                absorb(8'h00);
            for (int i = 0; i < 8; i++)
                absorb(bits[63 - 8 * i -: 8]);
            inner = chain;
            key_block(8'h5c);
            for (int i = 0; i < 64; i++)
                blk[i] = 8'h00;
            for (int i = 0; i < 32; i++)
                blk[i] = inner[i >> 2][31 - 8 * (i & 3) -: 8];
            blk[32] = 8'h80;
            blk[62] = 8'h03;
            compress();
            for (int k = 0; k < 4; k++)
                pending.push_back('{{chain[2*k], chain[2*k+1]}, k[1:0], k == 3});
            chain = h0;
            byte_count = 0;
            in_message = 0;
        endfunction

        function void check_mac(bit [63:0] word, bit [1:0] index, bit final_word);
            mac_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected mac item: word %h index %0d", word, index);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (word !== e.word)
            begin
                $error("mac_word: expected %h actual %h", e.word, word);
                errors++;
            end
            if (index !== e.index)
            begin
                $error("mac_index: expected %0d actual %0d", e.index, index);
                errors++;
            end
            if (final_word !== e.final_word)
            begin
                $error("mac_final: expected %0d actual %0d", e.final_word, final_word);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;

    mac_board sb = new;
    int idle_pct = 0;
    int stall_pct = 0;
    int sent = 0;

    hmac_sha256_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_mac(m_axis_tdata[63:0], m_axis_tdata[65:64], m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // leaves cfg_we high; caller lowers it after the last write
    task write_reg(cfg_idx_t idx, bit [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task load_key(bit [63:0] k0, bit [63:0] k1, bit [63:0] k2, bit [63:0] k3,
                  bit [5:0] len);
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_KLEN, {58'd0, len});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task send_item(bit [63:0] word, bit [3:0] nbytes, bit last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, nbytes, word};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_item(word, nbytes, last);
        sent++;
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task send_msg(int words, bit ragged);
        for (int j = 0; j < words; j++)
            send_item({$urandom, $urandom}, ragged ? 4'($urandom_range(15)) : 4'd8,
                      j == words - 1);
    endtask

    function bit [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: all zero, length 32
        send_item('0, 4'd0, 1'b1);
        send_item('1, 4'd8, 1'b1);
        load_key('1, '1, '1, '1, 6'd32);
        send_item('0, 4'd15, 1'b0);
        send_item('1, 4'd0, 1'b0);
        send_item(64'h0123456789abcdef, 4'd3, 1'b1);
        load_key(rnd64(), rnd64(), rnd64(), rnd64(), 6'd0);
        send_msg(8, 0);
        load_key(rnd64(), rnd64(), rnd64(), rnd64(), 6'd1);
        send_msg(6, 0);
        send_item(rnd64(), 4'd7, 1'b1);
        load_key(rnd64(), rnd64(), rnd64(), rnd64(), 6'd63);
        send_msg(7, 0);
        load_key('0, '0, '0, '0, 6'd33);
        send_msg(2, 1);

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 15 : 0;
            stall_pct = (ph == 2) ? 65 : (ph == 3) ? 15 : 0;
            load_key(rnd64(), rnd64(), rnd64(), rnd64(), 6'($urandom_range(63)));
            sent = 0;
            while (sent < 40)
                send_msg($urandom_range(1, 12), $urandom_range(3) == 0);
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
